/* design/note_sine_tone_generator_assert.svh */
// Assertion macros for the design files; snt_phase includes them.
`ifndef NOTE_SINE_TONE_GENERATOR_ASSERT_SVH
`define NOTE_SINE_TONE_GENERATOR_ASSERT_SVH

// Implication checked in the same cycle.
`define SNT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define SNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/snt_pkg.sv */
package snt_pkg;

    localparam int NOTE_COUNT   = 32;
    localparam int PHASE_BITS   = 32;
    localparam int SINE_ENTRIES = 1024;

    localparam int NOTE_W   = 5;
    localparam int AMP_W    = 15;
    localparam int LEN_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int SINE_W   = 15;
    localparam int SINE_AW  = $clog2(SINE_ENTRIES);
    localparam int INC_AW   = $clog2(NOTE_COUNT);

    localparam int unsigned SAMPLE_RATE = 44100;
    localparam int unsigned BASE_HZ     = 440;
    localparam int          RATIO_FRAC  = 24;
    localparam int unsigned HALF_PI_Q30 = 1686629713;
    localparam int unsigned SINE_MAX    = 32767;

    // Configuration register indexes.
    localparam logic CFG_AMPLITUDE   = 1'b0;
    localparam logic CFG_NOTE_LENGTH = 1'b1;

    localparam int unsigned SEMITONE_Q24 [12] = '{
        16777216, 17774841, 18831788, 19951585, 21137968, 22394897,
        23726566, 25137421, 26632170, 28215802, 29893600, 31671166
    };

    // Taylor series divisors (2i)(2i+1) for i = 1..6.
    localparam int unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

    typedef logic [PHASE_BITS-1:0] t_inc_rom [NOTE_COUNT];
    typedef logic [SINE_W-1:0]     t_sine_rom [SINE_ENTRIES+1];

    // Control that travels alongside the data through the pipeline.
    typedef struct packed {
        logic valid;
        logic neg;
        logic note_end;
    } t_stage;

    // Phase increment for note n, rounded half up, modulo 2^PHASE_BITS.
    function automatic logic [PHASE_BITS-1:0] note_increment(int n);
        int d;
        int oct;
        int s;
        int e;
        int m;
        int i;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] r;
        d = n - 10;
        if (d >= 0) begin
            oct = d / 12;
        end else begin
            oct = -((-d + 11) / 12);
        end
        s   = d - 12 * oct;
        e   = PHASE_BITS + oct - RATIO_FRAC;
        num = 64'(BASE_HZ) * 64'(SEMITONE_Q24[s]);
        if (e <= 0) begin
            m = -e;
            if (m == 0) begin
                q = (num + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE;
            end else begin
                q = ((num + (64'(SAMPLE_RATE) << (m - 1))) >> m) / SAMPLE_RATE;
            end
        end else begin
            q = num / SAMPLE_RATE;
            r = num % SAMPLE_RATE;
            for (i = 0; i < e; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= 64'(SAMPLE_RATE)) begin
                    r = r - 64'(SAMPLE_RATE);
                    q = q | 64'd1;
                end
            end
            if ((r << 1) >= 64'(SAMPLE_RATE)) begin
                q = q + 64'd1;
            end
        end
        return q[PHASE_BITS-1:0];
    endfunction

    function automatic t_inc_rom build_inc_rom();
        t_inc_rom rom;
        int n;
        for (n = 0; n < NOTE_COUNT; n++) begin
            rom[n] = note_increment(n);
        end
        return rom;
    endfunction

    // Quarter-wave sine entry k in unsigned Q0.15, from a Q30 Taylor series.
    function automatic logic [SINE_W-1:0] sine_entry(int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        int          i;
        x    = (64'(HALF_PI_Q30) * 64'(k) + 64'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (i = 1; i <= 6; i++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[i-1];
            if (i[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * 64'(SINE_MAX) + (64'd1 << 29)) >> 30;
        if (v > 64'(SINE_MAX)) begin
            v = 64'(SINE_MAX);
        end
        return v[SINE_W-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        int unsigned k;
        for (k = 0; k <= SINE_ENTRIES; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

endpackage

/* design/snt_phase.sv */
module snt_phase (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [snt_pkg::NOTE_W-1:0]   i_note,
    input  logic [snt_pkg::LEN_W-1:0]    i_note_length,
    output logic [snt_pkg::SINE_AW:0]    o_k,
    output snt_pkg::t_stage              o_ctrl
);
    import snt_pkg::*;

    `include "note_sine_tone_generator_assert.svh"

    localparam t_inc_rom INC_ROM = build_inc_rom();

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [LEN_W-1:0]      r_count;
    logic [LEN_W-1:0]      n_count;
    logic [LEN_W-1:0]      count_inc;
    logic [INC_AW-1:0]     inc_idx;
    logic [SINE_AW-1:0]    idx;
    logic [1:0]            quad;
    logic                  note_end;

    always_comb begin
        if (32'(i_note) >= 32'(NOTE_COUNT)) begin
            inc_idx = INC_AW'(NOTE_COUNT - 1);
        end else begin
            inc_idx = INC_AW'(i_note);
        end
    end

    assign quad      = r_phase[PHASE_BITS-1 -: 2];
    assign idx       = r_phase[PHASE_BITS-3 -: SINE_AW];
    assign o_k       = quad[0] ? ((SINE_AW+1)'(SINE_ENTRIES) - {1'b0, idx}) : {1'b0, idx};
    assign count_inc = r_count + LEN_W'(1);
    assign note_end  = (count_inc == i_note_length);

    assign o_ctrl.valid    = i_accept;
    assign o_ctrl.neg      = quad[1];
    assign o_ctrl.note_end = note_end;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (i_accept) begin
            if (note_end) begin
                n_phase = '0;
                n_count = '0;
            end else begin
                n_phase = r_phase + INC_ROM[inc_idx];
                n_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    `SNT_ASSERT_NEXT(a_note_restart, i_clk, i_rst_n, i_accept && note_end,
        r_phase == '0 && r_count == '0, "note end did not restart phase and count")
    `SNT_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_accept && !note_end,
        r_count == LEN_W'($past(r_count) + LEN_W'(1)), "sample counter did not step")
    `SNT_ASSERT_NEXT(a_hold_idle, i_clk, i_rst_n, !i_accept,
        $stable(r_phase) && $stable(r_count), "state moved without an input beat")

endmodule

/* design/snt_sine_rom.sv */
module snt_sine_rom (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [snt_pkg::SINE_AW:0]     i_k,
    input  snt_pkg::t_stage               i_ctrl,
    output logic [snt_pkg::SINE_W-1:0]    o_sine,
    output snt_pkg::t_stage               o_ctrl
);
    import snt_pkg::*;

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic [SINE_W-1:0] r_sine;
    t_stage            r_ctrl;

    // Registered read of the quarter-wave table.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine <= SINE_ROM[i_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    assign o_sine = r_sine;
    assign o_ctrl = r_ctrl;

endmodule

/* design/snt_scale.sv */
module snt_scale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [snt_pkg::AMP_W-1:0]      i_amplitude,
    input  logic [snt_pkg::SINE_W-1:0]     i_sine,
    input  snt_pkg::t_stage                i_ctrl,
    output logic                           o_valid,
    output logic [snt_pkg::SAMPLE_W-1:0]   o_sample,
    output logic                           o_note_end
);
    import snt_pkg::*;

    logic [AMP_W+SINE_W-1:0] product;
    logic [SINE_W-1:0]       mag;
    logic [SAMPLE_W-1:0]     n_sample;
    logic [SAMPLE_W-1:0]     r_sample;
    logic                    r_note_end;
    logic                    r_valid;

    assign product  = (AMP_W+SINE_W)'(i_amplitude) * (AMP_W+SINE_W)'(i_sine);
    assign mag      = product[AMP_W+SINE_W-1 -: SINE_W];
    assign n_sample = i_ctrl.neg ? (SAMPLE_W'(0) - SAMPLE_W'(mag)) : SAMPLE_W'(mag);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sample   <= n_sample;
            r_note_end <= i_ctrl.note_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctrl.valid;
        end
    end

    assign o_valid    = r_valid;
    assign o_sample   = r_sample;
    assign o_note_end = r_note_end;

endmodule

/* design/note_sine_tone_generator.sv */
// Channel   | Direction | Payload
// ----------+-----------+------------------------------------------------
// s stream  | in        | tdata: note [4:0], zero padded to 8 bits
// m stream  | out       | tdata: sample [15:0]; tlast: note_end
// cfg write | in        | index 0 amplitude [14:0], index 1 note_length [15:0]
//
// A beat is taken in every cycle in which the output register is empty or is being
// emptied. The sine table is read into a register at the accepting edge, and the scaled
// sample is then registered in the output register, from which the beat leaves.
// All stages advance together, so a stall on the output side holds every stage.
// Reset is synchronous and active low; it clears the phase, the sample counter,
// the stage valid flags and loads the default amplitude and note length.
module note_sine_tone_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream: tdata holds note in bits [4:0], bits [7:5] are zero.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // Output stream: tdata holds sample in bits [15:0].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import snt_pkg::*;

    logic [AMP_W-1:0]   r_amplitude;
    logic [LEN_W-1:0]   r_note_length;
    logic               pipe_en;
    logic               accept;
    logic [SINE_AW:0]   sine_k;
    t_stage             ctrl_phase;
    t_stage             ctrl_rom;
    logic [SINE_W-1:0]  sine_val;

    // Configuration registers; the user must write them only while the pipeline is idle, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude   <= AMP_W'(32700);
            r_note_length <= LEN_W'(4410);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_AMPLITUDE:   r_amplitude   <= i_cfg_wdata[AMP_W-1:0];
                CFG_NOTE_LENGTH: r_note_length <= i_cfg_wdata[LEN_W-1:0];
                default:         r_amplitude   <= r_amplitude;
            endcase
        end
    end

    // The whole pipeline moves whenever the output register can take a beat.
    assign pipe_en    = !o_m_tvalid || i_m_tready;
    assign o_s_tready = pipe_en;
    assign accept     = i_s_tvalid && pipe_en;

    snt_phase u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_note        (i_s_tdata[NOTE_W-1:0]),
        .i_note_length (r_note_length),
        .o_k           (sine_k),
        .o_ctrl        (ctrl_phase)
    );

    snt_sine_rom u_sine_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_k     (sine_k),
        .i_ctrl  (ctrl_phase),
        .o_sine  (sine_val),
        .o_ctrl  (ctrl_rom)
    );

    snt_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_amplitude (r_amplitude),
        .i_sine      (sine_val),
        .i_ctrl      (ctrl_rom),
        .o_valid     (o_m_tvalid),
        .o_sample    (o_m_tdata),
        .o_note_end  (o_m_tlast)
    );

endmodule
